// ----- hw/rtl/wps_pkg.sv -----
// shared types and constants for the waypoint sequencer
package wps_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMED_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 3'd4;

    // configuration reset values
    localparam logic        RST_TIMED_MODE     = 1'b0;
    localparam logic [14:0] RST_ARRIVAL_RADIUS = 15'd51;
    localparam logic [7:0]  RST_DWELL_LIMIT    = 8'd10;
    localparam logic [15:0] RST_STEP_TICKS     = 16'd100;
    localparam logic [7:0]  RST_WAYPOINT_COUNT = 8'd4;

    // tick counter saturation point
    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    // request opcodes
    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_POSITION = 2'd1,
        OP_BUTTONS  = 2'd2,
        OP_TICK     = 2'd3
    } t_opcode;

    // one request
    typedef struct packed {
        t_opcode            opcode;
        logic [6:0]         load_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic               button_start;
        logic               button_land;
        logic               button_run;
        logic               button_hold;
    } t_req;

    // one result
    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic [6:0]         target_index;
    } t_result;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DECIDE,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic position;
        logic buttons;
        logic timed_update;
        logic rd_en;
        logic square;
        logic pos_update;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic control_on;
        logic running;
        logic timed_mode;
    } t_status;

endpackage

// ----- hw/rtl/wps_ctrl.sv -----
// controller state machine for the waypoint sequencer
module wps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  wps_pkg::t_opcode i_opcode,
    input  wps_pkg::t_status i_status,
    output logic             busy,
    output wps_pkg::t_cmd    o_cmd
);

    wps_pkg::t_state r_state;
    wps_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = start && !busy;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            wps_pkg::S_IDLE: begin
                busy = 1'b0;
                if (w_accept) begin
                    unique case (i_opcode)
                        wps_pkg::OP_LOAD:     o_cmd.load     = 1'b1;
                        wps_pkg::OP_POSITION: o_cmd.position = 1'b1;
                        wps_pkg::OP_BUTTONS:  o_cmd.buttons  = 1'b1;
                        wps_pkg::OP_TICK: begin
                            // tick with control off does nothing
                            if (i_status.control_on) begin
                                if (!i_status.running) begin
                                    o_cmd.rd_en = 1'b1;
                                    n_state     = wps_pkg::S_EMIT;
                                end else if (i_status.timed_mode) begin
                                    o_cmd.timed_update = 1'b1;
                                    n_state            = wps_pkg::S_EMIT_RD;
                                end else begin
                                    o_cmd.rd_en = 1'b1;
                                    n_state     = wps_pkg::S_SQUARE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wps_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = wps_pkg::S_DECIDE;
            end
            wps_pkg::S_DECIDE: begin
                o_cmd.pos_update = 1'b1;
                n_state          = wps_pkg::S_EMIT_RD;
            end
            wps_pkg::S_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = wps_pkg::S_EMIT;
            end
            wps_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = wps_pkg::S_IDLE;
            end
            default: n_state = wps_pkg::S_IDLE;
        endcase
    end

    // emit always uses data read in the cycle before
    a_emit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> $past(o_cmd.rd_en))
        else $error("emit without preceding table read");

    // squares are always followed by the arrival decision
    a_square_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.square |=> o_cmd.pos_update)
        else $error("arrival decision missing after squares");

    // a non-tick request completes in its accept cycle
    a_simple_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode != wps_pkg::OP_TICK) |=> !busy)
        else $error("non-tick request left the block busy");

    // at most one state-changing command at a time
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.position, o_cmd.buttons, o_cmd.timed_update,
                  o_cmd.square, o_cmd.pos_update, o_cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

// ----- hw/rtl/wps_datapath.sv -----
// datapath of the waypoint sequencer: table, position, flags, counters, distance
module wps_datapath #(
    parameter int MAX_WAYPOINTS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wps_pkg::t_req                     i_req,
    input  wps_pkg::t_cmd                     i_cmd,
    output wps_pkg::t_status                  o_status,
    output wps_pkg::t_result                  o_result,
    output logic                              o_result_valid
);

    localparam int IW = $clog2(MAX_WAYPOINTS);
    localparam int NW = (IW >= 8) ? IW + 1 : 8;

    // configuration
    logic        r_timed_mode;
    logic [14:0] r_radius;
    logic [7:0]  r_dwell;
    logic [15:0] r_step;
    logic [7:0]  r_wp_count;

    // waypoint table and read data
    logic [47:0]        r_table [MAX_WAYPOINTS];
    logic [47:0]        r_rdata;

    // measured position
    logic signed [15:0] r_meas_x;
    logic signed [15:0] r_meas_y;
    logic signed [15:0] r_meas_z;

    // control state
    logic          r_control_on;
    logic          r_running;
    logic [IW-1:0] r_index;
    logic [16:0]   r_ticks;
    logic          n_control_on;
    logic          n_running;
    logic [IW-1:0] n_index;
    logic [16:0]   n_ticks;

    // distance pipeline
    logic [31:0] r_sq_x;
    logic [31:0] r_sq_y;
    logic [31:0] r_sq_z;
    logic [29:0] r_radius_sq;

    // result
    wps_pkg::t_result r_result;
    logic             r_result_valid;

    logic [16:0]   w_ticks_inc;
    logic [16:0]   w_ticks_cand;
    logic [33:0]   w_dist_sq;
    logic          w_inside;
    logic [NW-1:0] w_n_eff;
    logic [NW-1:0] w_idx_plus;
    logic [IW-1:0] w_next_index;
    logic          w_load_ok;
    logic [15:0]   w_abs_x;
    logic [15:0]   w_abs_y;
    logic [15:0]   w_abs_z;

    // magnitude of a coordinate difference, fits 16 bits unsigned
    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 16'(-d) : d[15:0];
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timed_mode <= wps_pkg::RST_TIMED_MODE;
            r_radius     <= wps_pkg::RST_ARRIVAL_RADIUS;
            r_dwell      <= wps_pkg::RST_DWELL_LIMIT;
            r_step       <= wps_pkg::RST_STEP_TICKS;
            r_wp_count   <= wps_pkg::RST_WAYPOINT_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wps_pkg::CFG_TIMED_MODE:     r_timed_mode <= i_cfg_data[0];
                wps_pkg::CFG_ARRIVAL_RADIUS: r_radius     <= i_cfg_data[14:0];
                wps_pkg::CFG_DWELL_LIMIT:    r_dwell      <= i_cfg_data[7:0];
                wps_pkg::CFG_STEP_TICKS:     r_step       <= i_cfg_data;
                wps_pkg::CFG_WAYPOINT_COUNT: r_wp_count   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // table write and registered read
    assign w_load_ok = 32'(i_req.load_index) < 32'(MAX_WAYPOINTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_table[IW'(i_req.load_index)] <= {i_req.coord_x, i_req.coord_y, i_req.coord_z};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_table[r_index];
        end
    end

    // per-axis squared distance and squared radius
    assign w_abs_x = abs_diff(r_rdata[47:32], r_meas_x);
    assign w_abs_y = abs_diff(r_rdata[31:16], r_meas_y);
    assign w_abs_z = abs_diff(r_rdata[15:0],  r_meas_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq_x      <= w_abs_x * w_abs_x;
            r_sq_y      <= w_abs_y * w_abs_y;
            r_sq_z      <= w_abs_z * w_abs_z;
            r_radius_sq <= r_radius * r_radius;
        end
    end

    // strict arrival compare
    assign w_dist_sq = {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};
    assign w_inside  = w_dist_sq < {4'b0000, r_radius_sq};

    // saturating tick increment
    assign w_ticks_inc = (r_ticks == wps_pkg::TICK_MAX) ? r_ticks : r_ticks + 17'd1;

    // index advance with wrap at the effective count
    always_comb begin
        w_n_eff = NW'(r_wp_count);
        if (r_wp_count == 8'd0) begin
            w_n_eff = NW'(1);
        end else if (w_n_eff > NW'(MAX_WAYPOINTS)) begin
            w_n_eff = NW'(MAX_WAYPOINTS);
        end
        w_idx_plus   = NW'(r_index) + NW'(1);
        w_next_index = (w_idx_plus < w_n_eff) ? IW'(w_idx_plus) : '0;
    end

    // next values of flags, counter and index
    always_comb begin
        n_control_on = r_control_on;
        n_running    = r_running;
        n_index      = r_index;
        n_ticks      = r_ticks;
        w_ticks_cand = w_ticks_inc;
        if (i_cmd.buttons) begin
            if ((i_req.button_start && !r_control_on) || (i_req.button_land && r_control_on))
            begin
                n_control_on = !r_control_on;
                n_running    = 1'b0;
            end else if ((i_req.button_run && !r_running) ||
                         (i_req.button_hold && r_running)) begin
                n_running = !r_running;
            end
        end
        if (i_cmd.timed_update) begin
            if (w_ticks_inc > {1'b0, r_step}) begin
                n_ticks = '0;
                n_index = w_next_index;
            end else begin
                n_ticks = w_ticks_inc;
            end
        end
        if (i_cmd.pos_update) begin
            w_ticks_cand = w_inside ? w_ticks_inc : r_ticks;
            if (w_ticks_cand > {9'b0, r_dwell}) begin
                n_ticks = '0;
                n_index = w_next_index;
            end else begin
                n_ticks = w_ticks_cand;
            end
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control_on <= 1'b0;
            r_running    <= 1'b0;
            r_index      <= '0;
            r_ticks      <= '0;
            r_meas_x     <= '0;
            r_meas_y     <= '0;
            r_meas_z     <= '0;
        end else begin
            r_control_on <= n_control_on;
            r_running    <= n_running;
            r_index      <= n_index;
            r_ticks      <= n_ticks;
            if (i_cmd.position) begin
                r_meas_x <= i_req.coord_x;
                r_meas_y <= i_req.coord_y;
                r_meas_z <= i_req.coord_z;
            end
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_result.target_x     <= r_rdata[47:32];
            r_result.target_y     <= r_rdata[31:16];
            r_result.target_z     <= r_rdata[15:0];
            r_result.target_index <= 7'(r_index);
        end
    end

    assign o_result            = r_result;
    assign o_result_valid      = r_result_valid;
    assign o_status.control_on = r_control_on;
    assign o_status.running    = r_running;
    assign o_status.timed_mode = r_timed_mode;

endmodule

// ----- hw/rtl/waypoint_sequencer.sv -----
// top level of the waypoint sequencer
// A request is taken when start is high and busy is low. Load, position and button
// requests and a tick with control off complete in their accept cycle; the last gives no
// result. A tick with control on gives one result: when stopped, the controller goes to
// EMIT; in timed mode, through EMIT_RD to EMIT; in position mode, through SQUARE, DECIDE
// and EMIT_RD to EMIT. These steps follow from the single read port of the waypoint
// table with its registered read data, read once for the arrival check and once for the
// emitted waypoint, and from the registered squaring stage. The result is shown for one
// cycle with o_result_valid as busy falls, and cannot be held off by the receiver.
module waypoint_sequencer #(
    parameter int MAX_WAYPOINTS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  wps_pkg::t_req                  i_req,
    output wps_pkg::t_result               o_result,
    output logic                           o_result_valid,
    input  logic                           i_cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wps_pkg::t_cmd    w_cmd;
    wps_pkg::t_status w_status;

    // sequencing control
    wps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_req.opcode),
        .i_status (w_status),
        .busy     (busy),
        .o_cmd    (w_cmd)
    );

    // storage and arithmetic
    wps_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req          (i_req),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
